// ----- hw/rtl/kitp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kitp_pkg;
	localparam int EXP_BYTES_D = 4;
	localparam int MAX_IMPORT_BYTES_D = 2048;
	localparam int MAX_LEN_FIELD_BYTES_D = 2;
	localparam int NUM_COMPONENTS_D = 6;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_DATA = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_LEN = 2'd2;
	localparam logic [1:0] ST_DATA = 2'd3;

	localparam logic [1:0] REG_KEY_IS_RSA = 2'd0;
	localparam logic [1:0] REG_PRIVATE_LEN = 2'd1;
	localparam logic [1:0] REG_PUBLIC_LEN = 2'd2;
	localparam logic [1:0] REG_TOTAL_LENGTH = 2'd3;

	localparam logic [7:0] TAG_7F = 8'h7F;
	localparam logic [7:0] TAG_48 = 8'h48;
	localparam logic [7:0] TAG_5F = 8'h5F;
	localparam logic [7:0] TAG_ECC_PRI = 8'h92;
	localparam logic [7:0] TAG_ECC_PUB = 8'h99;
	localparam logic [7:0] TAG_RSA_BASE = 8'h91;
	localparam logic [15:0] TEMPLATE_MAX = 16'h0016;
	localparam logic [31:0] PRIME_FLOOR = 32'hB504F334;
	localparam logic [7:0] LEN_LONG = 8'h80;

	// Item queued from front to back
	typedef struct packed {
		logic [1:0] req;
		logic [7:0] data;
	} kitp_item_t;

	// Result record
	typedef struct packed {
		logic [1:0] status;
		logic       wvalid;
		logic [2:0] comp;
		logic [7:0] off;
		logic [7:0] wbyte;
	} kitp_res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/kitp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kitp_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  wire [1:0]            req_type,
	input  wire [7:0]            data_byte,
	output kitp_pkg::kitp_item_t item,
	output logic                 item_valid,
	input  wire                  item_take
);
	import kitp_pkg::*;

	// Two-entry queue toward the back end
	kitp_item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push;

	assign full = cnt_q[1];
	assign do_push = push && !full;
	assign item_valid = cnt_q != 2'd0;
	assign item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= !wp_q;
			if (item_take) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, item_take};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q].req <= req_type;
			mem_q[wp_q].data <= data_byte;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/kitp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kitp_back #(
	parameter int EXP_BYTES = kitp_pkg::EXP_BYTES_D,
	parameter int MAX_IMPORT_BYTES = kitp_pkg::MAX_IMPORT_BYTES_D,
	parameter int MAX_LEN_FIELD_BYTES = kitp_pkg::MAX_LEN_FIELD_BYTES_D,
	parameter int NUM_COMPONENTS = kitp_pkg::NUM_COMPONENTS_D
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  key_is_rsa,
	input  wire [8:0]            private_len,
	input  wire [7:0]            public_len,
	input  wire [15:0]           total_length,
	input  kitp_pkg::kitp_item_t item,
	input  wire                  item_valid,
	output logic                 item_take,
	output kitp_pkg::kitp_res_t  res,
	output logic                 res_valid,
	input  wire                  res_take
);
	import kitp_pkg::*;

	localparam logic [2:0] NCOMP = 3'(NUM_COMPONENTS);
	localparam logic [8:0] EXPB = 9'(EXP_BYTES);
	localparam logic [15:0] MAXIMP = 16'(MAX_IMPORT_BYTES);
	localparam logic [6:0] MAXLF = 7'(MAX_LEN_FIELD_BYTES);

	typedef enum logic [9:0] {
		PH_TAG_7F = 10'b0000000001, PH_TAG_48 = 10'b0000000010,
		PH_TPL_LEN = 10'b0000000100, PH_TPL_TAG = 10'b0000001000,
		PH_TPL_VLEN = 10'b0000010000, PH_TAG_5F = 10'b0000100000,
		PH_TAG_48B = 10'b0001000000, PH_DATA_LEN = 10'b0010000000,
		PH_DATA = 10'b0100000000, PH_DONE = 10'b1000000000
	} phase_t;

	// Skip pass: after a component ends or the data length is taken, steps over
	// empty components before the next item is taken
	typedef enum logic [1:0] {
		BK_RUN = 2'b01, BK_SKIP = 2'b10
	} bk_t;

	phase_t      phase_q, ph_n;
	bk_t         bk_q;
	logic [15:0] seen_q, seen_n;
	logic        lf_q, lf_n;
	logic [1:0]  lcnt_q, lcnt_n, ltak_q, ltak_n;
	logic [15:0] lacc_q, lacc_n, tend_q, tend_n, dtot_q, dtot_n;
	logic [2:0]  cidx_q, cidx_n;
	logic [8:0]  clen_q [6];
	logic [8:0]  clen_w;
	logic        clen_we;
	logic [8:0]  coff_q, coff_n;
	logic [31:0] ptop_q, ptop_n, qtop_q, qtop_n;
	logic        err_q, err_n;
	logic        skip_n;
	kitp_res_t   r;

	logic [8:0]  pri;
	logic [2:0]  lim;
	logic        go;
	logic [7:0]  b;
	logic        lrdy, lbad;
	logic [15:0] lval, lsum;
	logic [8:0]  cl, off, olim;
	logic [1:0]  st;
	logic [4:0]  sh;

	assign pri = (private_len > 9'd256) ? 9'd256 : private_len;
	assign lim = key_is_rsa ? NCOMP : ((clen_q[1] == 9'd0) ? 3'd1 : 3'd2);
	assign b = item.data;
	assign cl = clen_q[cidx_q];

	// Output register: accept a new item when empty or draining, outside a skip pass
	assign go = (bk_q == BK_RUN) && item_valid && (!res_valid || res_take);
	assign item_take = go;

	always_comb begin
		ph_n = phase_q; seen_n = seen_q; lf_n = lf_q; lcnt_n = lcnt_q;
		ltak_n = ltak_q; lacc_n = lacc_q; tend_n = tend_q; dtot_n = dtot_q;
		cidx_n = cidx_q; coff_n = coff_q; ptop_n = ptop_q; qtop_n = qtop_q;
		err_n = err_q; clen_w = 9'd0; clen_we = 1'b0; skip_n = 1'b0;
		r = '0; st = ST_OK; lrdy = 1'b0; lbad = 1'b0; lval = 16'd0;
		lsum = 16'd0; off = 9'd0; olim = 9'd0; sh = 5'd0;
		// BER length decoder
		if (!lf_q) begin
			if (!b[7]) begin
				lrdy = 1'b1; lval = {8'd0, b};
			end else if (b[6:0] == 7'd0 || b[6:0] > MAXLF || b[6:0] > 7'd2) begin
				lbad = 1'b1;
			end
		end else begin
			lval = {lacc_q[7:0], b};
			lrdy = (ltak_q + 2'd1) >= lcnt_q;
		end
		lsum = seen_q + 16'd1 + lval;
		if (item.req == REQ_START) begin
			ph_n = PH_TAG_7F; seen_n = '0; lf_n = 0; lcnt_n = 0; ltak_n = 0;
			lacc_n = 0; tend_n = 0; cidx_n = 0; dtot_n = 0; coff_n = 0;
			ptop_n = 0; qtop_n = 0; err_n = 0; skip_n = 1'b1;
		end else if (item.req == REQ_UNUSED || err_q) begin
			st = ST_DATA;
		end else if (item.req == REQ_FINISH) begin
			if (total_length > MAXIMP || seen_q != total_length || phase_q != PH_DONE)
				st = ST_LEN;
			else if (key_is_rsa && (ptop_q < PRIME_FLOOR || qtop_q < PRIME_FLOOR))
				st = ST_DATA;
			else
				st = ST_DONE;
		end else if (total_length > MAXIMP) begin
			st = ST_LEN;
		end else if (seen_q >= total_length || phase_q == PH_DONE) begin
			st = ST_DATA;
		end else begin
			seen_n = seen_q + 16'd1;
			case (phase_q)
				PH_TAG_7F: begin
					if (b != TAG_7F) st = ST_DATA; else ph_n = PH_TAG_48;
				end
				PH_TAG_48: begin
					if (b != TAG_48) st = ST_DATA; else ph_n = PH_TPL_LEN;
				end
				PH_TAG_5F: begin
					if (b != TAG_5F) st = ST_DATA; else ph_n = PH_TAG_48B;
				end
				PH_TAG_48B: begin
					if (b != TAG_48) st = ST_DATA; else ph_n = PH_DATA_LEN;
				end
				PH_TPL_TAG: begin
					if (key_is_rsa) begin
						if (cidx_q >= NCOMP || b != TAG_RSA_BASE + {5'd0, cidx_q})
							st = ST_DATA;
					end else if ((cidx_q == 3'd0 && b != TAG_ECC_PRI) ||
						(cidx_q == 3'd1 && b != TAG_ECC_PUB)) begin
						st = ST_DATA;
					end
					if (st == ST_OK) ph_n = PH_TPL_VLEN;
				end
				PH_TPL_LEN, PH_TPL_VLEN, PH_DATA_LEN: begin
					if (lbad) begin
						st = ST_LEN;
					end else if (!lrdy) begin
						if (!lf_q) begin
							lf_n = 1'b1; lcnt_n = b[1:0]; ltak_n = 0; lacc_n = 0;
						end else begin
							lacc_n = lval; ltak_n = ltak_q + 2'd1;
						end
					end else begin
						lf_n = 0; lcnt_n = 0; ltak_n = 0; lacc_n = lf_q ? lval : lacc_q;
						if (phase_q == PH_DATA_LEN) begin
							if (lval != dtot_q) st = ST_DATA;
							else begin
								cidx_n = 0; coff_n = 0; ph_n = PH_DATA; skip_n = 1'b1;
							end
						end else if ({1'b0, seen_q} + 17'd1 + {1'b0, lval} >
							{1'b0, total_length}) begin
							st = ST_LEN;
						end else if (phase_q == PH_TPL_LEN) begin
							if (lval > TEMPLATE_MAX) st = ST_DATA;
							else begin
								tend_n = lsum; cidx_n = 0; dtot_n = 0; ph_n = PH_TPL_TAG;
							end
						end else begin
							if (key_is_rsa) begin
								if (cidx_q >= NCOMP) st = ST_DATA;
								else if (cidx_q == 3'd0) begin
									if (lval != {7'd0, EXPB}) st = ST_DATA;
								end else if (cidx_q <= 3'd2) begin
									if (lval != {7'd0, pri}) st = ST_DATA;
								end else if (lval > {7'd0, pri}) st = ST_DATA;
							end else begin
								if (cidx_q == 3'd0) begin
									if (lval > {7'd0, pri}) st = ST_DATA;
								end else if (cidx_q == 3'd1) begin
									if (lval > {8'd0, public_len} + 16'd1) st = ST_DATA;
								end else st = ST_DATA;
							end
							if (st == ST_OK) begin
								clen_we = 1'b1; clen_w = lval[8:0];
								cidx_n = cidx_q + 3'd1;
								dtot_n = dtot_q + lval;
								if (seen_n == tend_q) begin
									if (key_is_rsa && cidx_n != NCOMP) st = ST_DATA;
									else begin
										cidx_n = 0; ph_n = PH_TAG_5F;
									end
								end else if (seen_n < tend_q) ph_n = PH_TPL_TAG;
								else st = ST_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					// phase is already past empty components here
					if (cidx_q >= 3'd6) st = ST_DATA;
					else if (key_is_rsa) begin
						off = (cidx_q >= 3'd3) ? pri - cl + coff_q : coff_q;
						olim = (cidx_q == 3'd0) ? EXPB : pri;
						if (cidx_q >= NCOMP || off >= olim) st = ST_DATA;
						else begin
							if (off < 9'd4) begin
								sh = 5'(8 * (3 - off[1:0]));
								if (cidx_q == 3'd1)
									ptop_n = (ptop_q & ~(32'hFF << sh)) | ({24'd0, b} << sh);
								if (cidx_q == 3'd2)
									qtop_n = (qtop_q & ~(32'hFF << sh)) | ({24'd0, b} << sh);
							end
							r.wvalid = 1'b1; r.comp = cidx_q; r.off = off[7:0]; r.wbyte = b;
						end
					end else if (cidx_q == 3'd0) begin
						off = pri - cl + coff_q;
						if (off >= pri) st = ST_DATA;
						else begin
							r.wvalid = 1'b1; r.off = off[7:0]; r.wbyte = b;
						end
					end else if (cidx_q != 3'd1 || clen_q[1] == 9'd0) st = ST_DATA;
					if (st == ST_OK) begin
						if (coff_q + 9'd1 == cl) begin
							coff_n = 0; cidx_n = cidx_q + 3'd1;
							if (cidx_n == lim) ph_n = PH_DONE; else skip_n = 1'b1;
						end else coff_n = coff_q + 9'd1;
					end
				end
				default: st = ST_DATA;
			endcase
		end
		if (st >= ST_LEN) begin
			ph_n = phase_q; seen_n = seen_q; lf_n = lf_q; lcnt_n = lcnt_q;
			ltak_n = ltak_q; lacc_n = lacc_q; tend_n = tend_q; dtot_n = dtot_q;
			cidx_n = cidx_q; coff_n = coff_q; ptop_n = ptop_q; qtop_n = qtop_q;
			clen_we = 1'b0; skip_n = 1'b0; r = '0;
			if (item.req != REQ_UNUSED && !err_q) err_n = 1'b1;
			// length bytes already consumed before the error stay consumed
			if (item.req == REQ_DATA && !err_q && total_length <= MAXIMP &&
				seen_q < total_length && phase_q != PH_DONE) begin
				seen_n = seen_q + 16'd1;
				if (phase_q == PH_DATA_LEN || phase_q == PH_TPL_LEN ||
					phase_q == PH_TPL_VLEN) begin
					if (lrdy) begin
						lf_n = 0; lcnt_n = 0; ltak_n = 0; lacc_n = lf_q ? lval : lacc_q;
					end
				end
				if (phase_q == PH_DATA) skip_n = 1'b0;
			end
		end
		r.status = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG_7F; bk_q <= BK_RUN; seen_q <= '0; lf_q <= 1'b0;
			lcnt_q <= '0; ltak_q <= '0; lacc_q <= '0; tend_q <= '0; dtot_q <= '0;
			cidx_q <= '0; coff_q <= '0; ptop_q <= '0; qtop_q <= '0; err_q <= 1'b0;
			res_valid <= 1'b0;
			for (int i = 0; i < 6; i++) clen_q[i] <= '0;
		end else begin
			res_valid <= go || (res_valid && !res_take);
			if (go) begin
				phase_q <= ph_n; seen_q <= seen_n; lf_q <= lf_n; lcnt_q <= lcnt_n;
				ltak_q <= ltak_n; lacc_q <= lacc_n; tend_q <= tend_n; dtot_q <= dtot_n;
				cidx_q <= cidx_n; coff_q <= coff_n; ptop_q <= ptop_n; qtop_q <= qtop_n;
				err_q <= err_n;
				if (item.req == REQ_START) begin
					for (int i = 0; i < 6; i++) clen_q[i] <= '0;
				end else if (clen_we) clen_q[cidx_q] <= clen_w;
				if (skip_n && (ph_n == PH_DATA)) bk_q <= BK_SKIP;
			end else if (bk_q == BK_SKIP) begin
				// step over empty components one per cycle
				if (phase_q != PH_DATA) bk_q <= BK_RUN;
				else if (cidx_q >= lim) begin
					phase_q <= PH_DONE; bk_q <= BK_RUN;
				end else if (clen_q[cidx_q] != 9'd0) bk_q <= BK_RUN;
				else cidx_q <= cidx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) res <= r;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/key_import_tlv_stream_parser_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake          | Payload
// input    | push / full        | req_type, data_byte
// result   | empty / pop        | status, write_valid, write_component, write_offset, write_byte
// config   | cfg_we             | cfg_index, cfg_wdata
// A two-entry queue feeds the back end, which takes one item per cycle into a
// result register while that register is empty or popped and no skip pass runs.
// After a component ends, or the data length is taken, the back end steps over
// empty components before it takes the next item.
// Sustained rate is one item per cycle with pop held high, outside skip passes.
// Reset clears all control state (queue entries and result payload are not reset); config resets to RSA off, 32, 64, 0.
module key_import_tlv_stream_parser_top #(
	parameter int EXP_BYTES = kitp_pkg::EXP_BYTES_D,
	parameter int MAX_IMPORT_BYTES = kitp_pkg::MAX_IMPORT_BYTES_D,
	parameter int MAX_LEN_FIELD_BYTES = kitp_pkg::MAX_LEN_FIELD_BYTES_D,
	parameter int NUM_COMPONENTS = kitp_pkg::NUM_COMPONENTS_D
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire [1:0]  req_type,
	input  wire [7:0]  data_byte,
	output logic       empty,
	input  wire        pop,
	output logic [1:0] status,
	output logic       write_valid,
	output logic [2:0] write_component,
	output logic [7:0] write_offset,
	output logic [7:0] write_byte,
	input  wire        cfg_we,
	input  wire [1:0]  cfg_index,
	input  wire [15:0] cfg_wdata
);
	import kitp_pkg::*;

	logic        rsa_q;
	logic [8:0]  pri_q;
	logic [7:0]  pub_q;
	logic [15:0] tot_q;
	kitp_item_t  item;
	logic        item_valid, item_take, res_valid;
	kitp_res_t   res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsa_q <= 1'b0; pri_q <= 9'd32; pub_q <= 8'd64; tot_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEY_IS_RSA: rsa_q <= cfg_wdata[0];
				REG_PRIVATE_LEN: pri_q <= cfg_wdata[8:0];
				REG_PUBLIC_LEN: pub_q <= cfg_wdata[7:0];
				REG_TOTAL_LENGTH: tot_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	kitp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .data_byte(data_byte),
		.item(item), .item_valid(item_valid), .item_take(item_take)
	);

	kitp_back #(
		.EXP_BYTES(EXP_BYTES), .MAX_IMPORT_BYTES(MAX_IMPORT_BYTES),
		.MAX_LEN_FIELD_BYTES(MAX_LEN_FIELD_BYTES), .NUM_COMPONENTS(NUM_COMPONENTS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .key_is_rsa(rsa_q), .private_len(pri_q),
		.public_len(pub_q), .total_length(tot_q), .item(item),
		.item_valid(item_valid), .item_take(item_take), .res(res),
		.res_valid(res_valid), .res_take(pop && res_valid)
	);

	assign empty = !res_valid;
	assign status = res.status;
	assign write_valid = res.wvalid;
	assign write_component = res.comp;
	assign write_offset = res.off;
	assign write_byte = res.wbyte;
endmodule
`default_nettype wire

// ----- bench/key_import_tlv_stream_parser_top_test.sv -----
`timescale 1ns / 1ps
module key_import_tlv_stream_parser_top_test;
	import kitp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD = 90;

	// parser phases
	localparam int unsigned PH_TAG_7F = 0, PH_TAG_48 = 1, PH_TPL_LEN = 2, PH_TPL_TAG = 3;
	localparam int unsigned PH_TPL_VLEN = 4, PH_TAG_5F = 5, PH_TAG_48B = 6;
	localparam int unsigned PH_DATA_LEN = 7, PH_DATA = 8, PH_DONE = 9;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic [1:0] req_type = REQ_START;
	logic [7:0] data_byte = 8'h00;
	logic empty;
	logic pop = 0;
	logic [1:0] status;
	logic write_valid;
	logic [2:0] write_component;
	logic [7:0] write_offset;
	logic [7:0] write_byte;
	logic cfg_we = 0;
	logic [1:0] cfg_index = REG_KEY_IS_RSA;
	logic [15:0] cfg_wdata = 16'h0;

	key_import_tlv_stream_parser_top i_dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	kitp_item_t pending_items[$];
	kitp_res_t expected_writes[$];
	logic [7:0] stream[$];
	int errors = 0;
	int results_seen = 0;
	bit quiet = 0;

	// shadow registers
	int unsigned m_rsa = 0, m_pri = 32, m_pub = 64, m_total = 0;
	// shadow parser state
	int unsigned phase, seen, lform, lcnt, ltaken, lacc, tend, cidx, dtot, coff;
	int unsigned ptop, qtop, err_sticky;
	int unsigned clens[6];
	int unsigned w_valid, w_comp, w_off, w_byte;

	function automatic int unsigned pri_eff();
		return m_pri > 256 ? 256 : m_pri;
	endfunction

	function automatic void clear_parser();
		phase = PH_TAG_7F;
		seen = 0; lform = 0; lcnt = 0; ltaken = 0; lacc = 0; tend = 0; cidx = 0;
		dtot = 0; coff = 0; ptop = 0; qtop = 0; err_sticky = 0;
		for (int i = 0; i < 6; i++) clens[i] = 0;
	endfunction

	// -1 bad length field, 0 more bytes needed, 1 length complete
	function automatic int feed_len(int unsigned b, output int unsigned len);
		int unsigned n;
		len = 0;
		if (!lform) begin
			if ((b & 8'h80) == 0) begin
				len = b;
				return 1;
			end
			n = b & 8'h7F;
			if (n == 0 || n > MAX_LEN_FIELD_BYTES_D || n > 2) return -1;
			lcnt = n; ltaken = 0; lacc = 0; lform = 1;
			return 0;
		end
		lacc = ((lacc << 8) | b) & 16'hFFFF;
		ltaken = (ltaken + 1) & 3;
		if (ltaken < lcnt) return 0;
		len = lacc;
		lform = 0; lcnt = 0; ltaken = 0;
		return 1;
	endfunction

	function automatic int unsigned comp_limit();
		if (m_rsa) return NUM_COMPONENTS_D;
		return clens[1] == 0 ? 1 : 2;
	endfunction

	function automatic void skip_empty();
		while (phase == PH_DATA) begin
			if (cidx >= comp_limit()) begin
				phase = PH_DONE;
				return;
			end
			if (clens[cidx] != 0) return;
			cidx++;
		end
	endfunction

	function automatic logic [1:0] template_len(int unsigned len);
		int unsigned pri;
		pri = pri_eff();
		if (seen + len > m_total) return ST_LEN;
		if (phase == PH_TPL_LEN) begin
			if (len > TEMPLATE_MAX) return ST_DATA;
			tend = (seen + len) & 16'hFFFF;
			cidx = 0; dtot = 0; phase = PH_TPL_TAG;
			return ST_OK;
		end
		if (m_rsa) begin
			if (cidx >= NUM_COMPONENTS_D) return ST_DATA;
			if (cidx == 0) begin
				if (len != EXP_BYTES_D) return ST_DATA;
			end else if (cidx <= 2) begin
				if (len != pri) return ST_DATA;
			end else if (len > pri) return ST_DATA;
		end else begin
			if (cidx == 0) begin
				if (len > pri) return ST_DATA;
			end else if (cidx == 1) begin
				if (len > m_pub + 1) return ST_DATA;
			end else return ST_DATA;
		end
		clens[cidx] = len & 9'h1FF;
		cidx++;
		dtot = (dtot + len) & 16'hFFFF;
		if (seen == tend) begin
			if (m_rsa ? cidx != NUM_COMPONENTS_D : cidx == 0) return ST_DATA;
			cidx = 0; phase = PH_TAG_5F;
		end else if (seen < tend) begin
			phase = PH_TPL_TAG;
		end else return ST_DATA;
		return ST_OK;
	endfunction

	function automatic logic [1:0] copy_key_byte(int unsigned b);
		int unsigned pri, idx, clen, off, lim, sh, m;
		pri = pri_eff();
		skip_empty();
		if (phase != PH_DATA || cidx >= 6) return ST_DATA;
		idx = cidx;
		clen = clens[idx];
		if (m_rsa) begin
			off = idx >= 3 ? pri - clen + coff : coff;
			lim = idx == 0 ? EXP_BYTES_D : pri;
			if (off >= lim) return ST_DATA;
			if (off < 4) begin
				sh = 8 * (3 - off);
				m = ~(32'hFF << sh);
				if (idx == 1) ptop = (ptop & m) | (b << sh);
				if (idx == 2) qtop = (qtop & m) | (b << sh);
			end
			w_valid = 1; w_comp = idx; w_off = off & 8'hFF; w_byte = b;
		end else if (idx == 0) begin
			off = pri - clen + coff;
			if (off >= pri) return ST_DATA;
			w_valid = 1; w_comp = 0; w_off = off & 8'hFF; w_byte = b;
		end else if (idx != 1 || clens[1] == 0) return ST_DATA;
		coff = (coff + 1) & 9'h1FF;
		if (coff == clen) begin
			coff = 0;
			cidx++;
			if (cidx == comp_limit()) phase = PH_DONE;
			else skip_empty();
		end
		return ST_OK;
	endfunction

	function automatic logic [1:0] take_byte(int unsigned b);
		int unsigned len;
		int r;
		if (m_total > MAX_IMPORT_BYTES_D) return ST_LEN;
		if (seen >= m_total || phase == PH_DONE) return ST_DATA;
		seen++;
		case (phase)
			PH_TAG_7F: begin
				if (b != TAG_7F) return ST_DATA;
				phase = PH_TAG_48;
			end
			PH_TAG_48: begin
				if (b != TAG_48) return ST_DATA;
				phase = PH_TPL_LEN;
			end
			PH_TPL_LEN, PH_TPL_VLEN: begin
				r = feed_len(b, len);
				if (r < 0) return ST_LEN;
				if (r > 0) return template_len(len);
			end
			PH_TPL_TAG: begin
				if (m_rsa) begin
					if (cidx >= NUM_COMPONENTS_D || b != TAG_RSA_BASE + cidx) return ST_DATA;
				end else if ((cidx == 0 && b != TAG_ECC_PRI) || (cidx == 1 && b != TAG_ECC_PUB))
					return ST_DATA;
				phase = PH_TPL_VLEN;
			end
			PH_TAG_5F: begin
				if (b != TAG_5F) return ST_DATA;
				phase = PH_TAG_48B;
			end
			PH_TAG_48B: begin
				if (b != TAG_48) return ST_DATA;
				phase = PH_DATA_LEN;
			end
			PH_DATA_LEN: begin
				r = feed_len(b, len);
				if (r < 0) return ST_LEN;
				if (r > 0) begin
					if (len != dtot) return ST_DATA;
					cidx = 0; coff = 0; phase = PH_DATA;
					skip_empty();
				end
			end
			PH_DATA: return copy_key_byte(b);
			default: return ST_DATA;
		endcase
		return ST_OK;
	endfunction

	function automatic logic [1:0] final_check();
		if (m_total > MAX_IMPORT_BYTES_D) return ST_LEN;
		if (seen != m_total || phase != PH_DONE) return ST_LEN;
		if (m_rsa && (ptop < PRIME_FLOOR || qtop < PRIME_FLOOR)) return ST_DATA;
		return ST_DONE;
	endfunction

	// expected result of one accepted transaction
	function automatic kitp_res_t predict_write(kitp_item_t it);
		kitp_res_t r;
		logic [1:0] st;
		w_valid = 0; w_comp = 0; w_off = 0; w_byte = 0;
		if (it.req == REQ_START) begin
			clear_parser();
			st = ST_OK;
		end else if (it.req == REQ_UNUSED || err_sticky) begin
			st = ST_DATA;
		end else begin
			st = it.req == REQ_DATA ? take_byte(it.data) : final_check();
			if (st >= ST_LEN) begin
				err_sticky = 1;
				w_valid = 0; w_comp = 0; w_off = 0; w_byte = 0;
			end
		end
		r.status = st;
		r.wvalid = w_valid[0];
		r.comp = w_comp[2:0];
		r.off = w_off[7:0];
		r.wbyte = w_byte[7:0];
		return r;
	endfunction

	// sender: feeds pending items, random idle bursts
	int push_gap = 0;
	always @(posedge clk) begin
		logic nxt_push;
		kitp_item_t nxt;
		if (push && !full) expected_writes.push_back(predict_write('{req_type, data_byte}));
		nxt_push = push;
		if (!push || !full) begin
			if (push_gap > 0) begin
				push_gap--;
				nxt_push = 0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				push_gap = $urandom_range(0, 13);
				nxt_push = 0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				req_type <= nxt.req;
				data_byte <= nxt.data;
				nxt_push = 1;
			end else nxt_push = 0;
		end
		push <= nxt_push;
	end

	// receiver: checks results, random stalls and one long hold-off
	int pop_gap = 0;
	int hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		kitp_res_t got, want;
		if (pop && !empty) begin
			got = '{status, write_valid, write_component, write_offset, write_byte};
			results_seen++;
			if (expected_writes.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $realtime, got);
				errors++;
			end else begin
				want = expected_writes.pop_front();
				if (got.status !== want.status)
					$display("%0t: status expected %0d actual %0d", $realtime, want.status,
						got.status);
				if (got.wvalid !== want.wvalid)
					$display("%0t: write_valid expected %0d actual %0d", $realtime,
						want.wvalid, got.wvalid);
				if (got.comp !== want.comp)
					$display("%0t: write_component expected %0d actual %0d", $realtime,
						want.comp, got.comp);
				if (got.off !== want.off)
					$display("%0t: write_offset expected %0d actual %0d", $realtime,
						want.off, got.off);
				if (got.wbyte !== want.wbyte)
					$display("%0t: write_byte expected %h actual %h", $realtime, want.wbyte,
						got.wbyte);
				if (got !== want) errors++;
			end
		end
		if (!hold_done && results_seen >= 400) begin
			hold_done = 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 0;
		end else if (pop_gap > 0) begin
			pop_gap--;
			pop <= 0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			pop_gap = $urandom_range(0, 13);
			pop <= 0;
		end else pop <= 1;
	end

	// watchdog: cycles with work in flight and no transaction
	int stuck = 0;
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (pending_items.size() == 0 && !push &&
			expected_writes.size() == 0))
			stuck = 0;
		else stuck++;
		if (stuck >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_items.size() != 0 || push || expected_writes.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val[15:0];
		case (idx)
			REG_KEY_IS_RSA: m_rsa = val & 1;
			REG_PRIVATE_LEN: m_pri = val & 9'h1FF;
			REG_PUBLIC_LEN: m_pub = val & 8'hFF;
			default: m_total = val & 16'hFFFF;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send(logic [1:0] req, logic [7:0] b);
		pending_items.push_back('{req, b});
	endtask

	// BER length, long form when needed and sometimes when not
	task automatic put_len(int unsigned len);
		if (len > 255 || (len > 0 && $urandom_range(0, 19) == 0)) begin
			stream.push_back(LEN_LONG | 8'd2);
			stream.push_back(len[15:8]);
			stream.push_back(len[7:0]);
		end else if (len > 127 || $urandom_range(0, 19) == 0) begin
			stream.push_back(LEN_LONG | 8'd1);
			stream.push_back(len[7:0]);
		end else stream.push_back(len[7:0]);
	endtask

	// builds one import for the current registers; returns its byte count
	task automatic build_import(output int unsigned nbytes);
		int unsigned pri, lens[6], ncomp, dsum, tpl;
		logic [7:0] tpl_body[$];
		pri = pri_eff();
		stream.delete();
		if (m_rsa) begin
			ncomp = 6;
			lens[0] = EXP_BYTES_D; lens[1] = pri; lens[2] = pri;
			for (int i = 3; i < 6; i++) lens[i] = $urandom_range(0, pri);
		end else begin
			lens[0] = $urandom_range(0, 3) == 0 ? $urandom_range(0, pri) : pri;
			ncomp = $urandom_range(0, 2) == 0 ? 1 : 2;
			lens[1] = $urandom_range(0, 3) == 0 ? $urandom_range(0, m_pub + 1) : m_pub + 1;
		end
		dsum = 0;
		for (int i = 0; i < ncomp; i++) begin
			stream.push_back(8'(m_rsa ? TAG_RSA_BASE + i :
				(i == 0 ? TAG_ECC_PRI : TAG_ECC_PUB)));
			put_len(lens[i]);
			dsum += lens[i];
		end
		tpl_body = stream;
		tpl = tpl_body.size();
		stream.delete();
		stream.push_back(TAG_7F);
		stream.push_back(TAG_48);
		put_len(tpl);
		foreach (tpl_body[i]) stream.push_back(tpl_body[i]);
		stream.push_back(TAG_5F);
		stream.push_back(TAG_48);
		put_len(dsum);
		for (int i = 0; i < ncomp; i++)
			for (int j = 0; j < lens[i]; j++) begin
				// prime tops mostly above the floor
				if (m_rsa && (i == 1 || i == 2) && j == 0 && $urandom_range(0, 4) != 0)
					stream.push_back(8'($urandom_range(8'hB6, 8'hFF)));
				else stream.push_back(8'($urandom_range(0, 255)));
			end
		nbytes = stream.size();
	endtask

	// one import: config, start, bytes, finish; optionally broken
	task automatic run_import(int unsigned rsa, int unsigned pri, int unsigned pub,
		int unsigned flaws);
		int unsigned n, tot;
		wait_idle();
		write_reg(REG_KEY_IS_RSA, rsa);
		write_reg(REG_PRIVATE_LEN, pri);
		write_reg(REG_PUBLIC_LEN, pub);
		build_import(n);
		tot = n;
		if (flaws && $urandom_range(0, 2) == 0) tot = n + $urandom_range(0, 2) - 1;
		write_reg(REG_TOTAL_LENGTH, tot);
		if (flaws && $urandom_range(0, 1) == 0)
			stream[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
		send(REQ_START, 8'($urandom_range(0, 255)));
		foreach (stream[i]) begin
			send(REQ_DATA, stream[i]);
			if (flaws && $urandom_range(0, 199) == 0)
				send(REQ_UNUSED, 8'($urandom_range(0, 255)));
		end
		if (flaws && $urandom_range(0, 5) == 0) send(REQ_DATA, 8'($urandom_range(0, 255)));
		send(REQ_FINISH, 8'($urandom_range(0, 255)));
		if (flaws && $urandom_range(0, 5) == 0) send(REQ_DATA, 8'($urandom_range(0, 255)));
	endtask

	// large sizes only while the item budget allows
	function automatic int unsigned pick_pri(bit big);
		case ($urandom_range(0, 19))
			0: return big ? 256 : 20;
			1: return big ? $urandom_range(257, 511) : 1;
			2: return 1;
			default: return $urandom_range(1, 20);
		endcase
	endfunction

	initial begin
		int unsigned total_items;
		clear_parser();
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// directed: empty total, unused code, too long, bad length fields
		send(REQ_FINISH, 8'h00);
		send(REQ_UNUSED, 8'hFF);
		send(REQ_START, 8'h00);
		send(REQ_DATA, TAG_7F);
		send(REQ_START, 8'h00);
		wait_idle();
		write_reg(REG_TOTAL_LENGTH, 16'hFFFF);
		send(REQ_DATA, TAG_7F);
		send(REQ_FINISH, 8'h00);
		send(REQ_START, 8'h00);
		wait_idle();
		write_reg(REG_TOTAL_LENGTH, 100);
		send(REQ_DATA, TAG_7F);
		send(REQ_DATA, TAG_48);
		send(REQ_DATA, LEN_LONG);
		send(REQ_DATA, TAG_7F);
		send(REQ_START, 8'h00);
		send(REQ_DATA, TAG_7F);
		send(REQ_DATA, TAG_48);
		send(REQ_DATA, LEN_LONG | 8'd3);
		send(REQ_START, 8'h00);
		send(REQ_DATA, 8'h00);
		total_items = 20;
		// well-formed extremes
		run_import(1, 256, 1, 0);
		total_items += stream.size() + 2;
		run_import(1, 1, 1, 0);
		total_items += stream.size() + 2;
		run_import(0, 511, 255, 0);
		total_items += stream.size() + 2;
		run_import(0, 1, 1, 0);
		total_items += stream.size() + 2;
		run_import(1, 4, 64, 0);
		total_items += stream.size() + 2;

		// random imports, mostly well-formed
		while (total_items < 1600) begin
			run_import($urandom_range(0, 1), pick_pri(total_items < 600),
				$urandom_range(0, 9) == 0 ? $urandom_range(1, 255) : $urandom_range(1, 20),
				$urandom_range(0, 3) == 0);
			total_items += stream.size() + 2;
		end
		// last part of the run with no idling
		quiet = 1;
		do begin
			run_import($urandom_range(0, 1), pick_pri(0), $urandom_range(1, 20),
				$urandom_range(0, 3) == 0);
			total_items += stream.size() + 2;
		end while (total_items < 1700);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
